/* design/alignment_difference_string_parser_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the alignment difference string parser
// Wrappers for clocked concurrent assertions; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_DIFFERENCE_STRING_PARSER_TOP_MACROS_SVH
`define ALIGNMENT_DIFFERENCE_STRING_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define ADSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adsp: assertion failed");
// Next-cycle implication, disabled during reset
`define ADSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adsp: assertion failed");
`else
`define ADSP_ASSERT_IMPL(label, ante, cons)
`define ADSP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/adsp_pkg.sv */
// ----------------------------------------------------------------------------
// Alignment difference string parser package
// Item types, parse modes, operation codes and character constants.
// ----------------------------------------------------------------------------
package adsp_pkg;

  localparam logic [30:0] MAX31    = 31'h7FFF_FFFF;
  localparam logic [15:0] DOT_PAIR = 16'h2E2E;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;

  // Rows one byte can produce: pending op, operator-at-end op, closing row
  localparam int unsigned GROUP_ROWS = 3;

  typedef enum logic [1:0] {
    OP_MATCH    = 2'd0,
    OP_MISMATCH = 2'd1,
    OP_INSERT   = 2'd2,
    OP_DELETE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_MATCH    = 3'd1,
    MODE_MIS_REF  = 3'd2,
    MODE_MIS_QRY  = 3'd3,
    MODE_MIS_DONE = 3'd4,
    MODE_INS      = 3'd5,
    MODE_DEL      = 3'd6
  } mode_e;

  typedef struct packed {
    logic [7:0]  ch;
    logic        last;
    logic [30:0] ref_start;
    logic [30:0] query_start;
    logic [30:0] query_end;
    logic        forward;
  } in_item_t;

  typedef struct packed {
    op_e                op;
    logic [30:0]        run_length;
    logic [15:0]        mutation;
    logic [30:0]        ref_pos;
    logic [30:0]        query_off;
    logic signed [31:0] query_pos;
    logic               row_last;
  } out_item_t;

  // Row before the query position is formed
  typedef struct packed {
    op_e         op;
    logic [30:0] run_length;
    logic [15:0] mutation;
    logic [30:0] ref_pos;
    logic [30:0] query_off;
    logic        row_last;
  } row_raw_t;

  // All rows caused by one item, plus the coordinates they share
  typedef struct packed {
    row_raw_t [GROUP_ROWS-1:0] rows;
    logic [1:0]                count;
    logic [30:0]               query_start;
    logic [30:0]               query_end;
    logic                      forward;
  } row_group_t;

  typedef struct packed {
    row_raw_t    row;
    logic [30:0] query_start;
    logic [30:0] query_end;
    logic        forward;
  } head_t;

  typedef struct packed {
    logic [1:0] remaining;
    logic       free;
  } buf_stat_t;

endpackage

/* design/adsp_parser.sv */
// ----------------------------------------------------------------------------
// Parser core
// Holds the parse state and turns one byte into its group of result rows.
// ----------------------------------------------------------------------------
module adsp_parser import adsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_accept_i,
  input  in_item_t   in_item_i,
  output row_group_t grp_o
);

  typedef struct packed {
    logic [30:0] ref_off;
    logic [30:0] qry_off;
    logic [30:0] match_len;
  } offs_t;

  function automatic logic [30:0] sat_add31(logic [30:0] a, logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? MAX31 : s[30:0];
  endfunction

  // Move the offsets past an emitted operation
  function automatic offs_t advance(mode_e m, logic [30:0] len, offs_t o);
    offs_t r;
    r = o;
    case (m)
      MODE_MATCH: begin
        r.ref_off   = sat_add31(o.ref_off, len);
        r.qry_off   = sat_add31(o.qry_off, len);
        r.match_len = len;
      end
      MODE_INS: r.qry_off = sat_add31(o.qry_off, len);
      MODE_DEL: r.ref_off = sat_add31(o.ref_off, len);
      MODE_MIS_REF, MODE_MIS_QRY, MODE_MIS_DONE: begin
        r.ref_off = sat_add31(o.ref_off, 31'd1);
        r.qry_off = sat_add31(o.qry_off, 31'd1);
      end
      default: r = o;
    endcase
    return r;
  endfunction

  function automatic op_e mode_op(mode_e m);
    op_e r;
    case (m)
      MODE_MATCH: r = OP_MATCH;
      MODE_INS:   r = OP_INSERT;
      MODE_DEL:   r = OP_DELETE;
      default:    r = OP_MISMATCH;
    endcase
    return r;
  endfunction

  mode_e       mode_q, mode_d, mode0, mode1;
  logic        at_start_q, at_start_d;
  logic [30:0] plen_q, plen_d, plen0, plen1;
  logic [15:0] pmut_q, pmut_d, pmut0, pmut1;
  logic [30:0] prpos_q, prpos_d, prpos1;
  logic [30:0] pqoff_q, pqoff_d, pqoff1;
  offs_t       offs_q, offs_d, o0, o1, o2;
  logic        is_op, is_digit, is_lower, emit_a, emit_b;
  logic [34:0] dec_v;

  // Apply the record-start reload
  always_comb begin
    mode0 = mode_q;
    plen0 = plen_q;
    pmut0 = pmut_q;
    o0    = offs_q;
    if (at_start_q) begin
      o0.ref_off   = sat_add31(in_item_i.ref_start, 31'd1);
      o0.qry_off   = {30'b0, in_item_i.forward};
      o0.match_len = '0;
      mode0        = MODE_IDLE;
      plen0        = '0;
      pmut0        = DOT_PAIR;
    end
  end

  assign is_op = (in_item_i.ch == CH_COLON) || (in_item_i.ch == CH_STAR) ||
                 (in_item_i.ch == CH_PLUS)  || (in_item_i.ch == CH_MINUS);
  assign is_digit = in_item_i.ch inside {[CH_0:CH_9]};
  assign is_lower = in_item_i.ch inside {[CH_A:CH_Z]};
  assign dec_v = ({4'b0, plen0} << 3) + ({4'b0, plen0} << 1) +
                 35'(in_item_i.ch - CH_0);

  // Consume the character
  always_comb begin
    mode1  = mode0;
    plen1  = plen0;
    pmut1  = pmut0;
    prpos1 = prpos_q;
    pqoff1 = pqoff_q;
    o1     = o0;
    emit_a = 1'b0;
    if (mode0 == MODE_MIS_REF) begin
      pmut1 = {in_item_i.ch, 8'h00};
      mode1 = MODE_MIS_QRY;
    end else if (mode0 == MODE_MIS_QRY) begin
      pmut1 = {pmut0[15:8], in_item_i.ch};
      mode1 = MODE_MIS_DONE;
    end else if (is_op) begin
      emit_a = (mode0 != MODE_IDLE);
      if (emit_a) begin
        o1 = advance(mode0, plen0, o0);
      end
      prpos1 = o1.ref_off;
      pqoff1 = o1.qry_off;
      plen1  = '0;
      pmut1  = DOT_PAIR;
      case (in_item_i.ch)
        CH_COLON: mode1 = MODE_MATCH;
        CH_STAR: begin
          mode1 = MODE_MIS_REF;
          plen1 = 31'd1;
          pmut1 = '0;
        end
        CH_PLUS: mode1 = MODE_INS;
        default: mode1 = MODE_DEL;
      endcase
    end else if (mode0 == MODE_MATCH && is_digit) begin
      plen1 = (|dec_v[34:31]) ? MAX31 : dec_v[30:0];
    end else if ((mode0 == MODE_INS || mode0 == MODE_DEL) && is_lower) begin
      plen1 = sat_add31(plen0, 31'd1);
    end
  end

  // Flush the pending operation at the record end
  always_comb begin
    emit_b = in_item_i.last && (mode1 != MODE_IDLE);
    o2     = emit_b ? advance(mode1, plen1, o1) : o1;
  end

  // Next state
  always_comb begin
    mode_d     = mode1;
    plen_d     = plen1;
    pmut_d     = pmut1;
    prpos_d    = prpos1;
    pqoff_d    = pqoff1;
    offs_d     = o2;
    at_start_d = 1'b0;
    if (in_item_i.last) begin
      mode_d     = MODE_IDLE;
      plen_d     = '0;
      pmut_d     = DOT_PAIR;
      at_start_d = 1'b1;
    end
  end

  // Build the row group, packed from slot zero
  always_comb begin
    logic [1:0] n;
    n     = '0;
    grp_o = '0;
    if (emit_a) begin
      grp_o.rows[n] = '{op: mode_op(mode0), run_length: plen0, mutation: pmut0,
                        ref_pos: prpos_q, query_off: pqoff_q, row_last: 1'b0};
      n = n + 2'd1;
    end
    if (emit_b) begin
      grp_o.rows[n] = '{op: mode_op(mode1), run_length: plen1, mutation: pmut1,
                        ref_pos: prpos1, query_off: pqoff1, row_last: 1'b0};
      n = n + 2'd1;
    end
    if (in_item_i.last) begin
      grp_o.rows[n] = '{op: OP_MATCH, run_length: o2.match_len, mutation: DOT_PAIR,
                        ref_pos: o2.ref_off, query_off: o2.qry_off, row_last: 1'b1};
      n = n + 2'd1;
    end
    grp_o.count       = n;
    grp_o.query_start = in_item_i.query_start;
    grp_o.query_end   = in_item_i.query_end;
    grp_o.forward     = in_item_i.forward;
  end

  // Advance the parse state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      at_start_q <= 1'b1;
      plen_q     <= '0;
      pmut_q     <= DOT_PAIR;
      prpos_q    <= '0;
      pqoff_q    <= '0;
      offs_q     <= '0;
    end else if (in_accept_i) begin
      mode_q     <= mode_d;
      at_start_q <= at_start_d;
      plen_q     <= plen_d;
      pmut_q     <= pmut_d;
      prpos_q    <= prpos_d;
      pqoff_q    <= pqoff_d;
      offs_q     <= offs_d;
    end
  end

endmodule

/* design/adsp_row_buf.sv */
// ----------------------------------------------------------------------------
// Row group buffer
// Holds the rows of one item and hands them out one per cycle as they are popped.
// ----------------------------------------------------------------------------
module adsp_row_buf import adsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  row_group_t grp_i,
  input  logic       pop_i,
  output logic       head_valid_o,
  output head_t      head_o,
  output buf_stat_t  stat_o
);

  row_raw_t [GROUP_ROWS-1:0] rows_q;
  logic [30:0] qs_q, qe_q;
  logic        fwd_q;
  logic [1:0]  cnt_q, idx_q;

  assign head_valid_o       = (cnt_q != 2'd0);
  assign head_o.row         = rows_q[idx_q];
  assign head_o.query_start = qs_q;
  assign head_o.query_end   = qe_q;
  assign head_o.forward     = fwd_q;

  // Take a new group once the last held row leaves
  assign stat_o.free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop_i);
  assign stat_o.remaining = cnt_q;

  // Track remaining rows and the read slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= grp_i.count;
      idx_q <= '0;
    end else if (pop_i) begin
      cnt_q <= cnt_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  // Hold the group payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rows_q <= grp_i.rows;
      qs_q   <= grp_i.query_start;
      qe_q   <= grp_i.query_end;
      fwd_q  <= grp_i.forward;
    end
  end

endmodule

/* design/adsp_out_stage.sv */
// ----------------------------------------------------------------------------
// Output stage
// Forms the query position of a row and holds it in the result register.
// ----------------------------------------------------------------------------
module adsp_out_stage import adsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  head_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic               valid_q;
  out_item_t          item_q;
  logic [31:0]        fwd_sum;
  logic signed [31:0] rev_diff, qpos;

  assign pop_o = head_valid_i && (!valid_q || !out_stall_i);

  // Forward: start plus offset, clipped at the signed max; reverse cannot overflow
  assign fwd_sum  = {1'b0, head_i.query_start} + {1'b0, head_i.row.query_off};
  assign rev_diff = $signed({1'b0, head_i.query_end}) -
                    $signed({1'b0, head_i.row.query_off});
  assign qpos = head_i.forward ? (fwd_sum[31] ? 32'sh7FFF_FFFF : $signed(fwd_sum))
                               : rev_diff;

  // Result valid: set on load, clear when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q.op         <= head_i.row.op;
      item_q.run_length <= head_i.row.run_length;
      item_q.mutation   <= head_i.row.mutation;
      item_q.ref_pos    <= head_i.row.ref_pos;
      item_q.query_off  <= head_i.row.query_off;
      item_q.query_pos  <= qpos;
      item_q.row_last   <= head_i.row.row_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* design/alignment_difference_string_parser_top.sv */
// ----------------------------------------------------------------------------
// Alignment difference string parser, top level
// Byte-wide short-form difference string parser with a one-row result port.
// ----------------------------------------------------------------------------
// The block takes one character of a difference string per cycle unless it
// stalls and returns rows of operations (match, mismatch, insertion,
// deletion) with reference and query positions; every record ends with a
// closing row. A byte yields zero, one, two or three rows. The parser works
// a byte combinationally and places its rows in a group buffer; the result
// register drains that buffer one row per cycle unless the receiver stalls,
// and each row moves from the group buffer into the result register. The
// input stalls while the buffer holds more than the row leaving in that cycle.
`include "alignment_difference_string_parser_top_macros.svh"

module alignment_difference_string_parser_top import adsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic       in_accept;
  row_group_t grp;
  logic       head_valid, pop;
  head_t      head;
  buf_stat_t  buf_stat;

  assign in_stall_o = !buf_stat.free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Parse one byte per accepted item
  adsp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_item_i   (in_item_i),
    .grp_o       (grp)
  );

  // Hold the rows of the latest item
  adsp_row_buf u_row_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .grp_i        (grp),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .stat_o       (buf_stat)
  );

  // Register one row per cycle toward the output unless the receiver stalls
  adsp_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

  // A record end always leaves at least its closing row in the buffer
  `ADSP_ASSERT_NEXT(a_last_leaves_rows, in_accept && in_item_i.last, buf_stat.remaining != 2'd0)
  // Two or more buffered rows must hold off the input
  `ADSP_ASSERT_IMPL(a_busy_stalls, buf_stat.remaining >= 2'd2, in_stall_o)
  // Buffered rows move into a free result register
  `ADSP_ASSERT_NEXT(a_drain, (buf_stat.remaining != 2'd0) && !(out_valid_o && out_stall_i), out_valid_o)

endmodule

/* test/tb_alignment_difference_string_parser_top.sv */
// ----------------------------------------------------------------------------
// Alignment difference string parser testbench
// Streams short-form difference strings into the parser one character per
// item, predicts the operation rows of every character and checks each row
// that leaves the block against the oldest prediction, under random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb_alignment_difference_string_parser_top;
  import adsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned ROW_LATENCY  = 8;
  localparam int unsigned RANDOM_CHARS = 110;
  localparam int unsigned HOLD_CYCLES  = 100;

  typedef logic [7:0] char_q_t[$];

  // Predict the rows of the parser and compare the rows it returns
  class diff_row_scoreboard;
    out_item_t   rows_due[$];
    int unsigned fail_count;
    mode_e       mode;
    bit          at_start;
    logic [30:0] pend_len;
    logic [15:0] pend_mut;
    logic [30:0] pend_rpos;
    logic [30:0] pend_qoff;
    logic [30:0] ref_off;
    logic [30:0] qry_off;
    logic [30:0] last_match;

    function new();
      fail_count = 0;
      mode       = MODE_IDLE;
      at_start   = 1'b1;
      pend_len   = '0;
      pend_mut   = DOT_PAIR;
      pend_rpos  = '0;
      pend_qoff  = '0;
      ref_off    = '0;
      qry_off    = '0;
      last_match = '0;
    endfunction

    function logic [30:0] sat_add(logic [30:0] a, logic [30:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      return (s > longint'(MAX31)) ? MAX31 : s[30:0];
    endfunction

    // Form one row; the query position uses the coordinates of the current item
    function void push_row(op_e op, logic [30:0] len, logic [15:0] mut,
                           logic [30:0] rpos, logic [30:0] qoff, in_item_t it,
                           logic closing);
      out_item_t r;
      longint    qp;
      qp = it.forward ? longint'(it.query_start) + longint'(qoff)
                      : longint'(it.query_end) - longint'(qoff);
      if (qp > longint'(32'h7FFF_FFFF)) qp = longint'(32'h7FFF_FFFF);
      if (qp < -longint'(32'h8000_0000)) qp = -longint'(32'h8000_0000);
      r.op         = op;
      r.run_length = len;
      r.mutation   = mut;
      r.ref_pos    = rpos;
      r.query_off  = qoff;
      r.query_pos  = qp[31:0];
      r.row_last   = closing;
      rows_due.push_back(r);
    endfunction

    // Emit the pending operation, then advance the offsets
    function void emit_pending(in_item_t it);
      op_e op;
      case (mode)
        MODE_MATCH: op = OP_MATCH;
        MODE_INS:   op = OP_INSERT;
        MODE_DEL:   op = OP_DELETE;
        default:    op = OP_MISMATCH;
      endcase
      push_row(op, pend_len, pend_mut, pend_rpos, pend_qoff, it, 1'b0);
      case (op)
        OP_MATCH: begin
          ref_off    = sat_add(ref_off, pend_len);
          qry_off    = sat_add(qry_off, pend_len);
          last_match = pend_len;
        end
        OP_MISMATCH: begin
          ref_off = sat_add(ref_off, 31'd1);
          qry_off = sat_add(qry_off, 31'd1);
        end
        OP_INSERT: qry_off = sat_add(qry_off, pend_len);
        default:   ref_off = sat_add(ref_off, pend_len);
      endcase
    endfunction

    // Work out the rows caused by one accepted character
    function void note_char(in_item_t it);
      longint acc;
      if (at_start) begin
        ref_off    = sat_add(it.ref_start, 31'd1);
        qry_off    = {30'd0, it.forward};
        last_match = '0;
        mode       = MODE_IDLE;
        pend_len   = '0;
        pend_mut   = DOT_PAIR;
        at_start   = 1'b0;
      end

      if (mode == MODE_MIS_REF) begin
        pend_mut = {it.ch, 8'h00};
        mode     = MODE_MIS_QRY;
      end else if (mode == MODE_MIS_QRY) begin
        pend_mut[7:0] = it.ch;
        mode          = MODE_MIS_DONE;
      end else if (it.ch == CH_COLON || it.ch == CH_STAR ||
                   it.ch == CH_PLUS || it.ch == CH_MINUS) begin
        if (mode != MODE_IDLE) emit_pending(it);
        pend_rpos = ref_off;
        pend_qoff = qry_off;
        pend_len  = '0;
        pend_mut  = DOT_PAIR;
        case (it.ch)
          CH_COLON: mode = MODE_MATCH;
          CH_STAR: begin
            mode     = MODE_MIS_REF;
            pend_len = 31'd1;
            pend_mut = '0;
          end
          CH_PLUS: mode = MODE_INS;
          default: mode = MODE_DEL;
        endcase
      end else if (mode == MODE_MATCH && it.ch >= CH_0 && it.ch <= CH_9) begin
        acc      = longint'(pend_len) * 10 + longint'(it.ch - CH_0);
        pend_len = (acc > longint'(MAX31)) ? MAX31 : acc[30:0];
      end else if ((mode == MODE_INS || mode == MODE_DEL) &&
                   it.ch >= CH_A && it.ch <= CH_Z) begin
        pend_len = sat_add(pend_len, 31'd1);
      end

      // Close the record: flush the pending op, then the closing row
      if (it.last) begin
        if (mode != MODE_IDLE) emit_pending(it);
        push_row(OP_MATCH, last_match, DOT_PAIR, ref_off, qry_off, it, 1'b1);
        mode     = MODE_IDLE;
        pend_len = '0;
        pend_mut = DOT_PAIR;
        at_start = 1'b1;
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    // Compare one returned row with the oldest prediction
    function void check_row(out_item_t got);
      out_item_t want;
      if (rows_due.size() == 0) begin
        fail_count++;
        $display("%0t: row with no prediction, expected none, got %p", $time, got);
        return;
      end
      want = rows_due.pop_front();
      check_field("op", 32'(want.op), 32'(got.op));
      check_field("run_length", 32'(want.run_length), 32'(got.run_length));
      check_field("mutation", 32'(want.mutation), 32'(got.mutation));
      check_field("ref_pos", 32'(want.ref_pos), 32'(got.ref_pos));
      check_field("query_off", 32'(want.query_off), 32'(got.query_off));
      check_field("query_pos", want.query_pos, got.query_pos);
      check_field("row_last", 32'(want.row_last), 32'(got.row_last));
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  diff_row_scoreboard row_board = new();
  int unsigned        burst_left  = 0;
  int unsigned        cycle_count = 0;
  bit                 rx_hold_req = 1'b0;

  alignment_difference_string_parser_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  always #5 clk_i = ~clk_i;

  // Offer one character, in bursts with random gaps, and hold it until taken
  task automatic send_char(in_item_t it);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(5, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    row_board.note_char(it);
  endtask

  task automatic send_record(char_q_t chars, logic [30:0] rs, logic [30:0] qs,
                             logic [30:0] qe, logic fwd);
    in_item_t it;
    foreach (chars[i]) begin
      it.ch          = chars[i];
      it.last        = (i == chars.size() - 1);
      it.ref_start   = rs;
      it.query_start = qs;
      it.query_end   = qe;
      it.forward     = fwd;
      send_char(it);
    end
  endtask

  // Pause the sender until every predicted row has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (row_board.rows_due.size() != 0) @(posedge clk_i);
    repeat (ROW_LATENCY) @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_coord(logic [30:0] top);
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return top;
      2, 3:    return 31'($urandom_range(1000, 0));
      default: return 31'($urandom_range(top, 0));
    endcase
  endfunction

  // Build one record: mostly well-formed ops, some noise and early cut-offs
  task automatic build_record(output char_q_t chars, output int unsigned useful);
    int unsigned n_ops;
    int unsigned n;
    chars  = {};
    useful = 0;
    n_ops  = $urandom_range(5, 1);
    if ($urandom_range(3, 0) == 0) chars.push_back(8'($urandom_range(255, 0)));
    repeat (n_ops) begin
      case ($urandom_range(3, 0))
        0: begin
          chars.push_back(CH_COLON);
          n = ($urandom_range(15, 0) == 0) ? $urandom_range(12, 10) : $urandom_range(3, 0);
          repeat (n) chars.push_back(CH_0 + 8'($urandom_range(9, 0)));
          useful += n + 1;
        end
        1: begin
          chars.push_back(CH_STAR);
          repeat (2) begin
            case ($urandom_range(5, 0))
              0:       chars.push_back("A");
              1:       chars.push_back("C");
              2:       chars.push_back("G");
              3:       chars.push_back("T");
              default: chars.push_back(8'($urandom_range(255, 0)));
            endcase
          end
          useful += 3;
        end
        default: begin
          chars.push_back(($urandom_range(1, 0) == 0) ? CH_PLUS : CH_MINUS);
          n = $urandom_range(4, 0);
          repeat (n) chars.push_back(CH_A + 8'($urandom_range(25, 0)));
          useful += n + 1;
        end
      endcase
      if ($urandom_range(7, 0) == 0) chars.push_back(8'($urandom_range(255, 0)));
    end
    // Cut some records short, possibly right after an operator
    if ($urandom_range(5, 0) == 0) begin
      n = $urandom_range(chars.size(), 1);
      while (chars.size() > n) void'(chars.pop_back());
      if (useful > n) useful = n;
    end
  endtask

  // Drive the receiver stall: one long hold-off on request, else random segments
  initial begin
    int unsigned hold_left;
    int unsigned seg_left;
    int unsigned stall_pct;
    hold_left = 0;
    seg_left  = 0;
    stall_pct = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          case ($urandom_range(3, 0))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          seg_left = $urandom_range(60, 10);
        end
        seg_left--;
        out_stall_i <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // Take rows: sample between edges, check at the accepting edge
  initial begin
    bit        take;
    out_item_t snap;
    forever begin
      @(negedge clk_i);
      take = rst_ni && out_valid_o && !out_stall_i;
      snap = out_item_o;
      @(posedge clk_i);
      if (take) row_board.check_row(snap);
    end
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    char_q_t     chars;
    int unsigned useful;
    int unsigned sent;
    bit          mid_pause_done;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Leading junk, every op, raw operator and zero bytes in a mismatch
    send_record('{"z", CH_COLON, "5", CH_STAR, CH_COLON, 8'h00, CH_PLUS, "a", "b",
                  CH_MINUS, "c"}, 31'd0, 31'd0, 31'd0, 1'b1);
    // Top ref start saturates the offsets; operator as last character
    send_record('{8'hFF, CH_COLON, "7", CH_MINUS}, 31'h7FFF_FFFE, MAX31, 31'd0, 1'b0);
    // Mismatch cut off after its reference byte; query position saturates
    send_record('{CH_COLON, "3", CH_STAR, "A"}, 31'd5, MAX31, MAX31, 1'b1);
    // Lone mismatch operator, then a record of one skipped byte
    send_record('{CH_STAR}, 31'd1234, 31'd77, 31'd900, 1'b0);
    send_record('{"q"}, 31'd0, 31'd10, MAX31, 1'b1);
    wait_drained();

    // Random records; hold off the receiver once while the sender keeps going
    rx_hold_req    = 1'b1;
    sent           = 0;
    mid_pause_done = 1'b0;
    while (sent < RANDOM_CHARS) begin
      build_record(chars, useful);
      send_record(chars, pick_coord(31'h7FFF_FFFE), pick_coord(MAX31),
                  pick_coord(MAX31), 1'($urandom_range(1, 0)));
      sent += useful;
      if (!mid_pause_done && sent >= RANDOM_CHARS / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
    end
    wait_drained();

    if (row_board.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/adsp_pkg.sv
design/adsp_parser.sv
design/adsp_row_buf.sv
design/adsp_out_stage.sv
design/alignment_difference_string_parser_top.sv
test/tb_alignment_difference_string_parser_top.sv
